// ===== rtl/core/cp437_pkg.sv =====
// Shared types, constants and code point mapping for the CP437 glyph row generator.
package cp437_pkg;

   localparam int GLYPH_ROWS_DEF  = 16;
   localparam int GLYPH_COUNT_DEF = 256;
   localparam int ADDR_W  = 12;
   localparam int CP_W    = 21;
   localparam int COLOR_W = 32;
   localparam int ROWIDX_W = 4;
   localparam int PIX_W   = 9;

   localparam logic [7:0] EXT_LO = 8'hB0;
   localparam logic [7:0] EXT_HI = 8'hDF;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_EMIT
   } ctl_state_type;

   typedef enum logic {
      REQ_WRITE  = 1'b0,
      REQ_RENDER = 1'b1
   } req_kind_type;

   // controller to datapath
   typedef struct packed {
      logic load;     // capture render request
      logic rd;       // issue store read for current row
      logic emit;     // present row on output register
      logic next_row; // advance row counter
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic at_last;  // row counter on final row
   } dp_sts_type;

   typedef struct packed {
      logic       repl;   // use built-in replacement glyph
      logic [7:0] glyph;
   } glyph_map_type;

   function automatic logic [7:0] repl_row(input logic [4:0] y);
      logic [7:0] r;
      case (y)
         5'd1:  r = 8'b00010000;
         5'd2:  r = 8'b00111000;
         5'd3:  r = 8'b01000100;
         5'd4:  r = 8'b10111010;
         5'd5:  r = 8'b10111010;
         5'd6:  r = 8'b11110110;
         5'd7:  r = 8'b11101110;
         5'd8:  r = 8'b11101110;
         5'd9:  r = 8'b11111110;
         5'd10: r = 8'b01101100;
         5'd11: r = 8'b00101000;
         5'd12: r = 8'b00010000;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   function automatic glyph_map_type map_code(input logic [CP_W-1:0] cp);
      glyph_map_type m;
      m.repl  = 1'b0;
      m.glyph = cp[7:0];
      case (cp)
         21'h263A: m.glyph = 8'd1;   21'h263B: m.glyph = 8'd2;
         21'h2665: m.glyph = 8'd3;   21'h2666: m.glyph = 8'd4;
         21'h2663: m.glyph = 8'd5;   21'h2660: m.glyph = 8'd6;
         21'h2022: m.glyph = 8'd7;   21'h25D8: m.glyph = 8'd8;
         21'h25CB: m.glyph = 8'd9;   21'h25D9: m.glyph = 8'd10;
         21'h2642: m.glyph = 8'd11;  21'h2640: m.glyph = 8'd12;
         21'h266A: m.glyph = 8'd13;  21'h266C: m.glyph = 8'd14;
         21'h263C: m.glyph = 8'd15;  21'h25BA: m.glyph = 8'd16;
         21'h25C4: m.glyph = 8'd17;  21'h2195: m.glyph = 8'd18;
         21'h203C: m.glyph = 8'd19;  21'h00B6: m.glyph = 8'd20;
         21'h00A7: m.glyph = 8'd21;  21'h25AC: m.glyph = 8'd22;
         21'h21A8: m.glyph = 8'd23;  21'h2191: m.glyph = 8'd24;
         21'h2193: m.glyph = 8'd25;  21'h2192: m.glyph = 8'd26;
         21'h2190: m.glyph = 8'd27;  21'h221F: m.glyph = 8'd28;
         21'h2194: m.glyph = 8'd29;  21'h25B2: m.glyph = 8'd30;
         21'h25BC: m.glyph = 8'd31;  21'h2302: m.glyph = 8'd127;
         21'h00C7: m.glyph = 8'd128; 21'h00FC: m.glyph = 8'd129;
         21'h00E9: m.glyph = 8'd130; 21'h00E2: m.glyph = 8'd131;
         21'h00E4: m.glyph = 8'd132; 21'h00E0: m.glyph = 8'd133;
         21'h00E5: m.glyph = 8'd134; 21'h00E7: m.glyph = 8'd135;
         21'h00EA: m.glyph = 8'd136; 21'h00EB: m.glyph = 8'd137;
         21'h00E8: m.glyph = 8'd138; 21'h00EF: m.glyph = 8'd139;
         21'h00EE: m.glyph = 8'd140; 21'h00EC: m.glyph = 8'd141;
         21'h00C4: m.glyph = 8'd142; 21'h00C5: m.glyph = 8'd143;
         21'h00C9: m.glyph = 8'd144; 21'h00E6: m.glyph = 8'd145;
         21'h00C6: m.glyph = 8'd146; 21'h00F4: m.glyph = 8'd147;
         21'h00F6: m.glyph = 8'd148; 21'h00F2: m.glyph = 8'd149;
         21'h00FB: m.glyph = 8'd150; 21'h00F9: m.glyph = 8'd151;
         21'h00FF: m.glyph = 8'd152; 21'h00D6: m.glyph = 8'd153;
         21'h00DC: m.glyph = 8'd154; 21'h00A2: m.glyph = 8'd155;
         21'h00A3: m.glyph = 8'd156; 21'h00A5: m.glyph = 8'd157;
         21'h20A7: m.glyph = 8'd158; 21'h0192: m.glyph = 8'd159;
         21'h00E1: m.glyph = 8'd160; 21'h00ED: m.glyph = 8'd161;
         21'h00F3: m.glyph = 8'd162; 21'h00FA: m.glyph = 8'd163;
         21'h00F1: m.glyph = 8'd164; 21'h00D1: m.glyph = 8'd165;
         21'h00AA: m.glyph = 8'd166; 21'h00BA: m.glyph = 8'd167;
         21'h00BF: m.glyph = 8'd168; 21'h2310: m.glyph = 8'd169;
         21'h00AC: m.glyph = 8'd170; 21'h00BD: m.glyph = 8'd171;
         21'h00BC: m.glyph = 8'd172; 21'h00A1: m.glyph = 8'd173;
         21'h00AB: m.glyph = 8'd174; 21'h00BB: m.glyph = 8'd175;
         21'h2591: m.glyph = 8'd176; 21'h2592: m.glyph = 8'd177;
         21'h2593: m.glyph = 8'd178; 21'h2502: m.glyph = 8'd179;
         21'h2524: m.glyph = 8'd180; 21'h2561: m.glyph = 8'd181;
         21'h2562: m.glyph = 8'd182; 21'h2556: m.glyph = 8'd183;
         21'h2555: m.glyph = 8'd184; 21'h2563: m.glyph = 8'd185;
         21'h2551: m.glyph = 8'd186; 21'h2557: m.glyph = 8'd187;
         21'h255D: m.glyph = 8'd188; 21'h255C: m.glyph = 8'd189;
         21'h255B: m.glyph = 8'd190; 21'h2510: m.glyph = 8'd191;
         21'h2514: m.glyph = 8'd192; 21'h2534: m.glyph = 8'd193;
         21'h252C: m.glyph = 8'd194; 21'h251C: m.glyph = 8'd195;
         21'h2500: m.glyph = 8'd196; 21'h253C: m.glyph = 8'd197;
         21'h255E: m.glyph = 8'd198; 21'h255F: m.glyph = 8'd199;
         21'h255A: m.glyph = 8'd200; 21'h2554: m.glyph = 8'd201;
         21'h2569: m.glyph = 8'd202; 21'h2566: m.glyph = 8'd203;
         21'h2560: m.glyph = 8'd204; 21'h2550: m.glyph = 8'd205;
         21'h256C: m.glyph = 8'd206; 21'h2567: m.glyph = 8'd207;
         21'h2568: m.glyph = 8'd208; 21'h2564: m.glyph = 8'd209;
         21'h2565: m.glyph = 8'd210; 21'h2559: m.glyph = 8'd211;
         21'h2558: m.glyph = 8'd212; 21'h2552: m.glyph = 8'd213;
         21'h2553: m.glyph = 8'd214; 21'h256B: m.glyph = 8'd215;
         21'h256A: m.glyph = 8'd216; 21'h2518: m.glyph = 8'd217;
         21'h250C: m.glyph = 8'd218; 21'h2588: m.glyph = 8'd219;
         21'h2584: m.glyph = 8'd220; 21'h258C: m.glyph = 8'd221;
         21'h2590: m.glyph = 8'd222; 21'h2580: m.glyph = 8'd223;
         21'h03B1: m.glyph = 8'd224; 21'h00DF: m.glyph = 8'd225;
         21'h03B2: m.glyph = 8'd225; 21'h0393: m.glyph = 8'd226;
         21'h03C0: m.glyph = 8'd227; 21'h03A3: m.glyph = 8'd228;
         21'h2211: m.glyph = 8'd228; 21'h03C3: m.glyph = 8'd229;
         21'h00B5: m.glyph = 8'd230; 21'h03C4: m.glyph = 8'd231;
         21'h03A6: m.glyph = 8'd232; 21'h0398: m.glyph = 8'd233;
         21'h03A9: m.glyph = 8'd234; 21'h03B4: m.glyph = 8'd235;
         21'h00F0: m.glyph = 8'd235; 21'h2202: m.glyph = 8'd235;
         21'h221E: m.glyph = 8'd236; 21'h03C6: m.glyph = 8'd237;
         21'h2205: m.glyph = 8'd237; 21'h03D5: m.glyph = 8'd237;
         21'h2300: m.glyph = 8'd237; 21'h00F8: m.glyph = 8'd237;
         21'h00D8: m.glyph = 8'd237; 21'h03B5: m.glyph = 8'd238;
         21'h2208: m.glyph = 8'd238; 21'h20AC: m.glyph = 8'd238;
         21'h2229: m.glyph = 8'd239; 21'h2261: m.glyph = 8'd240;
         21'h00B1: m.glyph = 8'd241; 21'h2265: m.glyph = 8'd242;
         21'h2264: m.glyph = 8'd243; 21'h2320: m.glyph = 8'd244;
         21'h2321: m.glyph = 8'd245; 21'h00F7: m.glyph = 8'd246;
         21'h2248: m.glyph = 8'd247; 21'h00B0: m.glyph = 8'd248;
         21'h2219: m.glyph = 8'd249; 21'h00B7: m.glyph = 8'd250;
         21'h221A: m.glyph = 8'd251; 21'h207F: m.glyph = 8'd252;
         21'h00B2: m.glyph = 8'd253; 21'h25A0: m.glyph = 8'd254;
         default: begin
            // printable ASCII and other Latin-1 map to themselves
            m.repl = (cp > 21'd255);
         end
      endcase
      return m;
   endfunction

endpackage

// ===== rtl/core/cp437_ctl.sv =====
// Controller state machine for the CP437 glyph row generator.
module cp437_ctl
   import cp437_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       render_go,
   input  logic       out_taken,
   input  dp_sts_type sts,
   output dp_cmd_type cmd,
   output logic       busy,
   output logic       out_valid
);

   ctl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      out_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (render_go) begin
               cmd.load = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.rd   = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            out_valid = 1'b1;
            if (out_taken) begin
               if (sts.at_last) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.next_row = 1'b1;
                  cmd.rd       = 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
      cmd.emit = out_valid;
   end

endmodule

// ===== rtl/core/cp437_dp.sv =====
// Datapath: glyph store, row counter and row formatting.
module cp437_dp
   import cp437_pkg::*;
#(
   parameter int GLYPH_ROWS  = GLYPH_ROWS_DEF,
   parameter int GLYPH_COUNT = GLYPH_COUNT_DEF
)(
   input  logic                clock,
   input  logic                wr_en,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  logic [7:0]          wr_data,
   input  logic [CP_W-1:0]     code_point,
   input  logic [COLOR_W-1:0]  fore_color,
   input  dp_cmd_type          cmd,
   output dp_sts_type          sts,
   output logic [ROWIDX_W-1:0] row_index,
   output logic [PIX_W-1:0]    row_pixels,
   output logic [COLOR_W-1:0]  pixel_color,
   output logic                last_row
);

   localparam int DEPTH = GLYPH_ROWS * GLYPH_COUNT;
   localparam int ROW_W = $clog2(GLYPH_ROWS);
   localparam int MA_W  = $clog2(DEPTH);

   logic [7:0] store_mem [DEPTH];
   logic [7:0] rd_data_ff;

   glyph_map_type       map_ff;
   logic                ext_ff;
   logic [COLOR_W-1:0]  color_ff;
   logic [ROW_W-1:0]    row_ff;
   logic [ROW_W-1:0]    rd_row;
   logic [MA_W-1:0]     rd_addr;
   glyph_map_type       map_in;
   logic [7:0]          bits;

   assign map_in = map_code(code_point);

   always_ff @(posedge clock) begin
      if (wr_en && ({20'd0, wr_addr} < 32'(DEPTH))) begin
         store_mem[MA_W'(wr_addr)] <= wr_data;
      end
      if (cmd.rd) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   assign rd_row  = cmd.next_row ? row_ff + 1'b1 : row_ff;
   assign rd_addr = MA_W'(map_ff.glyph) * MA_W'(GLYPH_ROWS) + MA_W'(rd_row);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         map_ff   <= map_in;
         ext_ff   <= !map_in.repl && map_in.glyph >= EXT_LO && map_in.glyph <= EXT_HI;
         color_ff <= fore_color;
         row_ff   <= '0;
      end else if (cmd.next_row) begin
         row_ff <= rd_row;
      end
   end

   assign bits = map_ff.repl ? repl_row(5'(row_ff)) : rd_data_ff;

   assign sts.at_last  = (row_ff == ROW_W'(GLYPH_ROWS - 1));
   assign row_index    = ROWIDX_W'(row_ff);
   assign row_pixels   = {bits, ext_ff & bits[0]};
   assign pixel_color  = color_ff;
   assign last_row     = sts.at_last & cmd.emit;

endmodule

// ===== rtl/core/cp437_glyph_row_generator.sv =====
// Top level of the CP437 glyph row generator.
// A render transfer is captured on acceptance, the READ state reads the glyph
// store and the first row is presented in the EMIT state. The single read port
// of the glyph store reads one row per cycle while the receiver takes rows;
// no new request is taken until the last row of a character has gone. Reset
// clears control state only; the glyph store holds garbage until loaded.
module cp437_glyph_row_generator
   import cp437_pkg::*;
#(
   parameter int GLYPH_ROWS  = GLYPH_ROWS_DEF,
   parameter int GLYPH_COUNT = GLYPH_COUNT_DEF
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [11:0] glyph_address, [19:12] glyph_byte, [40:20] code_point,
   // [72:41] fore_color, [79:73] zero
   input  logic [79:0] req_tdata,
   // [0] req_type
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [3:0] row_index, [12:4] row_pixels, [44:13] pixel_color, [47:45] zero
   output logic [47:0] rsp_tdata,
   output logic        rsp_tlast
);

   dp_cmd_type cmd;
   dp_sts_type sts;
   logic busy;
   logic accept;
   logic [ROWIDX_W-1:0] row_index;
   logic [PIX_W-1:0]    row_pixels;
   logic [COLOR_W-1:0]  pixel_color;

   assign req_tready = !busy;
   assign accept     = req_tvalid && req_tready;

   cp437_ctl u_ctl (
      .clock     (clock),
      .reset     (reset),
      .render_go (accept && req_tuser == REQ_RENDER),
      .out_taken (rsp_tready),
      .sts       (sts),
      .cmd       (cmd),
      .busy      (busy),
      .out_valid (rsp_tvalid)
   );

   cp437_dp #(
      .GLYPH_ROWS  (GLYPH_ROWS),
      .GLYPH_COUNT (GLYPH_COUNT)
   ) u_dp (
      .clock       (clock),
      .wr_en       (accept && req_tuser == REQ_WRITE),
      .wr_addr     (req_tdata[11:0]),
      .wr_data     (req_tdata[19:12]),
      .code_point  (req_tdata[40:20]),
      .fore_color  (req_tdata[72:41]),
      .cmd         (cmd),
      .sts         (sts),
      .row_index   (row_index),
      .row_pixels  (row_pixels),
      .pixel_color (pixel_color),
      .last_row    (rsp_tlast)
   );

   assign rsp_tdata = {3'd0, pixel_color, row_pixels, row_index};

endmodule

// ===== tb/cp437_glyph_row_generator_test.sv =====
// Testbench for the CP437 glyph row generator: loads the glyph store, renders, checks rows.
`timescale 1ns / 1ps

module cp437_glyph_row_generator_test;
   import cp437_pkg::*;

   localparam int ROWS      = 16;
   localparam int STORE_LEN = ROWS * 256;
   localparam int WATCHDOG  = 2000;
   localparam int N_RANDOM  = 400;
   localparam int PRESS_LEN = 120;

   typedef struct packed {
      req_kind_type      kind;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        bits;
      logic [CP_W-1:0]   cp;
      logic [COLOR_W-1:0] color;
   } glyph_req_t;

   typedef struct packed {
      logic [ROWIDX_W-1:0] row;
      logic [PIX_W-1:0]    pixels;
      logic [COLOR_W-1:0]  color;
      logic                last;
   } glyph_row_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [79:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic        rsp_tlast;

   cp437_glyph_row_generator dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast)
   );

   always #1 clock = ~clock;

   // stimulus and scoreboard state
   glyph_req_t pending_reqs[$];
   glyph_row_t expected_rows[$];
   logic [7:0] font_image[STORE_LEN];
   int  errors     = 0;
   bit  stim_done  = 1'b0;
   bit  quiet_tail = 1'b0;  // no idling near the end
   bit  press_req  = 1'b0;  // ask the receiver for a long hold-off
   int  idle_cycles = 0;

   // Replacement glyph as a table of its own, rows past 15 unlit.
   function automatic logic [7:0] tofu_row(input int y);
      logic [7:0] t [16];
      t = '{8'h00, 8'h10, 8'h38, 8'h44, 8'hBA, 8'hBA, 8'hF6, 8'hEE,
            8'hEE, 8'hFE, 8'h6C, 8'h28, 8'h10, 8'h00, 8'h00, 8'h00};
      return (y < 16) ? t[y] : 8'h00;
   endfunction

   // CP437 lookup: returns glyph index or -1 for the replacement glyph.
   function automatic int cp437_index(input logic [CP_W-1:0] cp);
      int codes [] = '{
         'h263A,'h263B,'h2665,'h2666,'h2663,'h2660,'h2022,'h25D8,'h25CB,'h25D9,
         'h2642,'h2640,'h266A,'h266C,'h263C,'h25BA,'h25C4,'h2195,'h203C,'h00B6,
         'h00A7,'h25AC,'h21A8,'h2191,'h2193,'h2192,'h2190,'h221F,'h2194,'h25B2,
         'h25BC,'h2302,'h00C7,'h00FC,'h00E9,'h00E2,'h00E4,'h00E0,'h00E5,'h00E7,
         'h00EA,'h00EB,'h00E8,'h00EF,'h00EE,'h00EC,'h00C4,'h00C5,'h00C9,'h00E6,
         'h00C6,'h00F4,'h00F6,'h00F2,'h00FB,'h00F9,'h00FF,'h00D6,'h00DC,'h00A2,
         'h00A3,'h00A5,'h20A7,'h0192,'h00E1,'h00ED,'h00F3,'h00FA,'h00F1,'h00D1,
         'h00AA,'h00BA,'h00BF,'h2310,'h00AC,'h00BD,'h00BC,'h00A1,'h00AB,'h00BB,
         'h2591,'h2592,'h2593,'h2502,'h2524,'h2561,'h2562,'h2556,'h2555,'h2563,
         'h2551,'h2557,'h255D,'h255C,'h255B,'h2510,'h2514,'h2534,'h252C,'h251C,
         'h2500,'h253C,'h255E,'h255F,'h255A,'h2554,'h2569,'h2566,'h2560,'h2550,
         'h256C,'h2567,'h2568,'h2564,'h2565,'h2559,'h2558,'h2552,'h2553,'h256B,
         'h256A,'h2518,'h250C,'h2588,'h2584,'h258C,'h2590,'h2580,
         'h03B1,'h00DF,'h03B2,'h0393,'h03C0,'h03A3,'h2211,'h03C3,'h00B5,'h03C4,
         'h03A6,'h0398,'h03A9,'h03B4,'h00F0,'h2202,'h221E,'h03C6,'h2205,'h03D5,
         'h2300,'h00F8,'h00D8,'h03B5,'h2208,'h20AC,'h2229,'h2261,'h00B1,'h2265,
         'h2264,'h2320,'h2321,'h00F7,'h2248,'h00B0,'h2219,'h00B7,'h221A,'h207F,
         'h00B2,'h25A0};
      int glyphs [] = '{
         1,2,3,4,5,6,7,8,9,10,11,12,13,14,15,16,17,18,19,20,
         21,22,23,24,25,26,27,28,29,30,31,127,128,129,130,131,132,133,134,135,
         136,137,138,139,140,141,142,143,144,145,146,147,148,149,150,151,152,
         153,154,155,156,157,158,159,160,161,162,163,164,165,166,167,168,169,
         170,171,172,173,174,175,
         176,177,178,179,180,181,182,183,184,185,186,187,188,189,190,191,192,
         193,194,195,196,197,198,199,200,201,202,203,204,205,206,207,208,209,
         210,211,212,213,214,215,216,217,218,219,220,221,222,223,
         224,225,225,226,227,228,228,229,230,231,232,233,234,235,235,235,236,
         237,237,237,237,237,237,238,238,238,239,240,241,242,243,244,245,246,
         247,248,249,250,251,252,253,254};
      if (cp >= 32 && cp < 127) return int'(cp);
      foreach (codes[i])
         if (codes[i] == cp) return glyphs[i];
      if (cp < 256) return int'(cp);
      return -1;
   endfunction

   // Apply one transfer to the font image and queue the rows it produces.
   task automatic predict_rows(input glyph_req_t r);
      int g;
      bit wide;
      logic [7:0] b;
      glyph_row_t e;
      if (r.kind == REQ_WRITE) begin
         if (r.addr < STORE_LEN) font_image[r.addr] = r.bits;
         return;
      end
      g = cp437_index(r.cp);
      wide = (g >= 'hB0 && g <= 'hDF);
      for (int y = 0; y < ROWS; y++) begin
         b = (g < 0) ? tofu_row(y) : font_image[g * ROWS + y];
         e.row    = y[ROWIDX_W-1:0];
         e.pixels = {b, wide & b[0]};
         e.color  = r.color;
         e.last   = (y == ROWS - 1);
         expected_rows.push_back(e);
      end
   endtask

   function automatic glyph_req_t font_write(input int a, input logic [7:0] v);
      glyph_req_t r;
      r = '0;
      r.kind = REQ_WRITE; r.addr = a[ADDR_W-1:0]; r.bits = v;
      r.cp = CP_W'($urandom); r.color = $urandom;  // don't-care fields toggle too
      return r;
   endfunction

   function automatic glyph_req_t render(input logic [CP_W-1:0] cp,
                                         input logic [31:0] c);
      glyph_req_t r;
      r.kind = REQ_RENDER; r.addr = ADDR_W'($urandom); r.bits = 8'($urandom);
      r.cp = cp; r.color = c;
      return r;
   endfunction

   function automatic logic [CP_W-1:0] random_cp();
      int sel;
      sel = $urandom_range(0, 9);
      case (sel)
         0, 1:    return CP_W'($urandom_range(32, 126));
         2, 3:    return CP_W'($urandom_range(0, 255));
         4, 5, 6: return CP_W'($urandom_range('h2000, 'h25FF));  // hits table entries
         7:       return CP_W'($urandom_range('h0300, 'h03FF));
         8:       return CP_W'($urandom_range(0, 'h10FFFF));
         default: return CP_W'($urandom);  // includes values beyond 0x10FFFF
      endcase
   endfunction

   // Driver: one transfer per handshake, random bursts of idle.
   int drv_gap = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            predict_rows(pending_reqs.pop_front());
         end
         if (req_tvalid && !req_tready) begin
            // hold the offered transfer
         end else if (drv_gap > 0) begin
            drv_gap <= drv_gap - 1;
            req_tvalid <= 1'b0;
         end else if (pending_reqs.size() > (req_tvalid && req_tready ? 0 : 0) &&
                      pending_reqs.size() != 0) begin
            if (!quiet_tail && $urandom_range(0, 7) == 0) begin
               drv_gap <= $urandom_range(0, 3);
               req_tvalid <= 1'b0;
            end else begin
               req_tvalid <= 1'b1;
               req_tuser  <= pending_reqs[0].kind;
               req_tdata  <= {7'd0, pending_reqs[0].color, pending_reqs[0].cp,
                              pending_reqs[0].bits, pending_reqs[0].addr};
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls plus one long hold-off on request.
   int  stall_left = 0;
   bit  press_done = 1'b0;
   always @(posedge clock) begin
      if (!reset) begin
         if (press_req && !press_done) begin
            press_done <= 1'b1;
            stall_left <= PRESS_LEN;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_tready <= 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 3);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Monitor: compare each accepted row with the oldest expectation.
   glyph_row_t got, want;
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (rsp_tvalid && rsp_tready) begin
            got.row    = rsp_tdata[3:0];
            got.pixels = rsp_tdata[12:4];
            got.color  = rsp_tdata[44:13];
            got.last   = rsp_tlast;
            if (expected_rows.size() == 0) begin
               $display("%0t: unexpected row, expected none actual %h", $time, got);
               errors = errors + 1;
            end else begin
               want = expected_rows.pop_front();
               if (got.row != want.row) begin
                  $display("%0t: row_index expected %0d actual %0d",
                           $time, want.row, got.row);
                  errors = errors + 1;
               end
               if (got.pixels != want.pixels) begin
                  $display("%0t: row_pixels expected %h actual %h",
                           $time, want.pixels, got.pixels);
                  errors = errors + 1;
               end
               if (got.color != want.color) begin
                  $display("%0t: pixel_color expected %h actual %h",
                           $time, want.color, got.color);
                  errors = errors + 1;
               end
               if (got.last != want.last) begin
                  $display("%0t: last_row expected %0d actual %0d",
                           $time, want.last, got.last);
                  errors = errors + 1;
               end
            end
         end
      end
   end

   // Watchdog on cycles without any transfer.
   always @(posedge clock) begin
      if (idle_cycles >= WATCHDOG) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      logic [CP_W-1:0] directed_cps [] = '{
         21'd32, 21'd126, 21'd0, 21'd127, 21'h2302, 21'h2591, 21'h2580, 21'h00DF,
         21'h25A0, 21'h00FF, 21'h0100, 21'h10FFFF, 21'h1FFFFF, 21'hB0, 21'hDF};
      // Full store load first: no unwritten entry is ever read.
      for (int a = 0; a < STORE_LEN; a++)
         pending_reqs.push_back(font_write(a, 8'($urandom)));
      // Directed: extreme colors and the corner code points.
      foreach (directed_cps[i])
         pending_reqs.push_back(render(directed_cps[i],
            (i % 3 == 0) ? 32'h0 : (i % 3 == 1) ? 32'hFFFF_FFFF : $urandom));
      pending_reqs.push_back(font_write(0, 8'hFF));
      pending_reqs.push_back(font_write(STORE_LEN - 1, 8'h00));
      pending_reqs.push_back(render(21'd0, $urandom));
      pending_reqs.push_back(render(21'h25A0, $urandom));
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      // Long receiver hold-off while the sender keeps offering renders and store writes.
      wait (pending_reqs.size() < 10);
      for (int i = 0; i < N_RANDOM; i++) begin
         if ($urandom_range(0, 3) == 0)
            pending_reqs.push_back(font_write($urandom_range(0, STORE_LEN - 1),
                                              8'($urandom)));
         else
            pending_reqs.push_back(render(random_cp(), $urandom));
      end
      @(posedge clock);
      press_req <= 1'b1;
      wait (pending_reqs.size() < 40);
      quiet_tail <= 1'b1;
      wait (pending_reqs.size() == 0 && expected_rows.size() == 0);
      repeat (40) @(posedge clock);
      if (errors == 0 && expected_rows.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== cp437_glyph_row_generator.f =====
rtl/core/cp437_pkg.sv
rtl/core/cp437_ctl.sv
rtl/core/cp437_dp.sv
rtl/core/cp437_glyph_row_generator.sv
tb/cp437_glyph_row_generator_test.sv
